/* sv/local_clustering_coefficient_assert.svh */
// Assertion macros used by the clustering coefficient checker.
`ifndef LOCAL_CLUSTERING_COEFFICIENT_ASSERT_SVH
`define LOCAL_CLUSTERING_COEFFICIENT_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define LCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clustering coefficient check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define LCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clustering coefficient check failed");

`endif

/* sv/lcc_pkg.sv */
// Shared types, codes and helpers of the clustering coefficient block.
package lcc_pkg;

	localparam int ROW_W   = 64;
	localparam int NODE_W  = 6;
	localparam int CNT_W   = 7;
	localparam int TRIAD_W = 12;
	localparam int OUT_W   = 16;

	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [TRIAD_W-1:0] triad_t;
	typedef logic [OUT_W-1:0]   fix_t;

	// what a row read is for
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ROW  = 2'd1,
		KIND_COL  = 2'd2,
		KIND_NBR  = 2'd3
	} kind_t;

	typedef struct packed {
		logic   wr_req;
		logic   clear_sum;
		logic   rd_en;
		kind_t  kind;
		node_t  rd_addr;
		node_t  node;
		count_t n;
		logic   div_start;
		logic   div_avg;
		logic   take_coef;
		logic   take_avg;
		logic   emit;
		logic   last;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic can_emit;
	} sts_t;

	// SWAR population count, six adder levels
	function automatic count_t popcount64(input row_t v);
		row_t s;
		s = (v & 64'h5555555555555555) + ((v >> 1) & 64'h5555555555555555);
		s = (s & 64'h3333333333333333) + ((s >> 2) & 64'h3333333333333333);
		s = (s & 64'h0F0F0F0F0F0F0F0F) + ((s >> 4) & 64'h0F0F0F0F0F0F0F0F);
		s = (s & 64'h00FF00FF00FF00FF) + ((s >> 8) & 64'h00FF00FF00FF00FF);
		s = (s & 64'h0000FFFF0000FFFF) + ((s >> 16) & 64'h0000FFFF0000FFFF);
		s = (s & 64'h00000000FFFFFFFF) + ((s >> 32) & 64'h00000000FFFFFFFF);
		return s[CNT_W-1:0];
	endfunction

endpackage

/* sv/local_clustering_coefficient.sv */
// Top level of the local clustering coefficient block.
// Input channel (in_valid/in_ready): mode 0 loads one adjacency row
//   (row_index, row_bits) into the row store, one item per cycle; mode 1
//   starts a walk over nodes 0 .. n-1, n being node_count clipped to 1..64.
// Config channel (cfg_valid/cfg_ready): writes node_count, always ready;
//   write it only while no compute is in flight.
// Output channel (out_valid/out_ready): one item per node, in node order,
//   with degree, triad count and Q1.15 coefficient; the last item carries
//   the average and has last set.
// Per node: the node's own row is read, then every row is read for the
//   incoming column, then every row again for the triad sum, a drain
//   state follows, then the bit-serial divider runs and the result is
//   written; the final node adds a second division for the mean.
//   The single read port of the row store and the divider set the
//   length of a walk.
// A load item is taken every cycle while idle; input is held off during
//   a walk. The result register decouples the sides: a stalled receiver
//   only holds the walk when the next result is ready to be written.
// Reset clears the sequencer, the running sum and sets node_count to 64;
//   the row store is not cleared, rows must be loaded before use.
module local_clustering_coefficient #(
	parameter int MAX_NODES     = 64,
	parameter int FRACTION_BITS = 15
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            mode,
	input  lcc_pkg::node_t  row_index,
	input  lcc_pkg::row_t   row_bits,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  lcc_pkg::count_t cfg_data,
	output logic            out_valid,
	input  logic            out_ready,
	output lcc_pkg::node_t  node_index,
	output lcc_pkg::node_t  degree,
	output lcc_pkg::triad_t triad_count,
	output lcc_pkg::fix_t   coefficient,
	output lcc_pkg::fix_t   average,
	output logic            last
);
	import lcc_pkg::*;

	// rows are 64 bits wide, so at most 64 nodes are ever stored
	localparam int ROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

	cmd_t cmd;
	sts_t sts;

	// sequencer and node count register
	lcc_ctrl #(
		.ROWS(ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

	// row store, accumulators, divider and result register
	lcc_datapath #(
		.ROWS         (ROWS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.row_index  (row_index),
		.row_bits   (row_bits),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.node_index (node_index),
		.degree     (degree),
		.triad_count(triad_count),
		.coefficient(coefficient),
		.average    (average),
		.last       (last)
	);

endmodule

/* sv/lcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lcc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/lcc_div.sv */
// Restoring divider, one quotient bit per cycle.
module lcc_div #(
	parameter int DW = 27,
	parameter int VW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] r_q;
	logic [DW-1:0] q_q;
	logic [VW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   shifted;
	logic [VW:0]   diff;
	logic          take;

	assign shifted = {r_q, q_q[DW-1]};
	assign diff    = shifted - {1'b0, d_q};
	assign take    = !diff[VW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= take ? diff[VW-1:0] : shifted[VW-1:0];
			q_q <= {q_q[DW-2:0], take};
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

endmodule

/* sv/lcc_datapath.sv */
// Datapath: row store, column and triad accumulation, divider, result register.
module lcc_datapath #(
	parameter int ROWS          = 64,
	parameter int FRACTION_BITS = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lcc_pkg::cmd_t  cmd,
	output lcc_pkg::sts_t  sts,
	input  lcc_pkg::node_t row_index,
	input  lcc_pkg::row_t  row_bits,
	input  logic           out_ready,
	output logic           out_valid,
	output lcc_pkg::node_t node_index,
	output lcc_pkg::node_t degree,
	output lcc_pkg::triad_t triad_count,
	output lcc_pkg::fix_t  coefficient,
	output lcc_pkg::fix_t  average,
	output logic           last
);
	import lcc_pkg::*;

	localparam int AW  = $clog2(ROWS);
	localparam int DVW = FRACTION_BITS + TRIAD_W;
	localparam int SW  = FRACTION_BITS + CNT_W;
	localparam logic [DVW-1:0] ONE = DVW'(1) << FRACTION_BITS;

	row_t           rdata;
	logic           wr_en;
	kind_t          kind_s1;
	node_t          tag_s1;
	row_t           use_mask;
	row_t           abit;
	row_t           row_a;
	row_t           rowa_q;
	row_t           incoming_q;
	node_t          deg_q;
	triad_t         triad_q;
	triad_t         triad_eff;
	triad_t         deg_w;
	triad_t         pair;
	logic           deg_ok;
	logic [DVW-1:0] div_dividend;
	triad_t         div_divisor;
	logic [DVW-1:0] quot;
	logic           div_done;
	logic [DVW-1:0] coef_sat;
	logic [DVW-1:0] coef_q;
	logic [DVW-1:0] avg_q;
	logic [SW-1:0]  sum_q;
	logic           out_valid_q;

	assign wr_en = cmd.wr_req && ({1'b0, row_index} < CNT_W'(ROWS));

	lcc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_rows (
		.clk  (clk),
		.we   (wr_en),
		.waddr(row_index[AW-1:0]),
		.wdata(row_bits),
		.raddr(cmd.rd_addr[AW-1:0]),
		.rdata(rdata)
	);

	assign use_mask = ~({ROW_W{1'b1}} << cmd.n);
	assign abit     = ROW_W'(1) << cmd.node;
	assign row_a    = rdata & use_mask & ~abit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= KIND_NONE;
		end else begin
			kind_s1 <= cmd.rd_en ? cmd.kind : KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= cmd.rd_addr;
		unique case (kind_s1)
			KIND_ROW: begin
				rowa_q     <= row_a;
				deg_q      <= NODE_W'(popcount64(row_a));
				incoming_q <= '0;
				triad_q    <= '0;
			end
			KIND_COL: begin
				incoming_q[tag_s1] <= rdata[cmd.node] && (tag_s1 != cmd.node);
			end
			KIND_NBR: begin
				if (rowa_q[tag_s1]) begin
					triad_q <= triad_q + TRIAD_W'(popcount64(rdata
						& ~(ROW_W'(1) << tag_s1) & incoming_q));
				end
			end
			KIND_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign deg_ok    = deg_q >= NODE_W'(2);
	assign triad_eff = deg_ok ? triad_q : '0;
	assign deg_w     = TRIAD_W'(deg_q);
	assign pair      = deg_w * (deg_w - TRIAD_W'(1));

	assign div_dividend = cmd.div_avg ? DVW'(sum_q) : (DVW'(triad_eff) << FRACTION_BITS);
	assign div_divisor  = cmd.div_avg ? TRIAD_W'(cmd.n) : (deg_ok ? pair : TRIAD_W'(1));

	lcc_div #(
		.DW(DVW),
		.VW(TRIAD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(quot),
		.done    (div_done)
	);

	// asymmetric rows can push the ratio past one
	assign coef_sat = (quot > ONE) ? ONE : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.clear_sum) begin
			sum_q <= '0;
		end else if (cmd.take_coef) begin
			sum_q <= sum_q + SW'(coef_sat);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_coef) begin
			coef_q <= coef_sat;
		end
		if (cmd.take_avg) begin
			avg_q <= quot;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			node_index  <= cmd.node;
			degree      <= deg_q;
			triad_count <= triad_eff;
			coefficient <= coef_q[OUT_W-1:0];
			average     <= cmd.last ? avg_q[OUT_W-1:0] : '0;
			last        <= cmd.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.div_done = div_done;
	assign sts.can_emit = !out_valid_q || out_ready;

endmodule

/* sv/lcc_ctrl.sv */
// Controller: node walk sequencer and node count register.
module lcc_ctrl #(
	parameter int ROWS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            mode,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  lcc_pkg::count_t cfg_data,
	output lcc_pkg::cmd_t   cmd,
	input  lcc_pkg::sts_t   sts
);
	import lcc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_ROW   = 10'b0000000010,
		S_COL   = 10'b0000000100,
		S_NBR   = 10'b0000001000,
		S_DRAIN = 10'b0000010000,
		S_DIVC  = 10'b0000100000,
		S_WAITC = 10'b0001000000,
		S_AVG   = 10'b0010000000,
		S_WAITA = 10'b0100000000,
		S_EMIT  = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	count_t nc_q;
	count_t n_q;
	count_t n_eff;
	node_t  a_q;
	node_t  a_d;
	node_t  idx_q;
	node_t  idx_d;
	logic   load_n;
	logic   last_node;
	logic   last_idx;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	assign n_eff = (nc_q == '0) ? CNT_W'(1)
		: ((nc_q > CNT_W'(ROWS)) ? CNT_W'(ROWS) : nc_q);

	assign last_node = ({1'b0, a_q} == n_q - CNT_W'(1));
	assign last_idx  = ({1'b0, idx_q} == n_q - CNT_W'(1));

	always_comb begin
		state_d     = state_q;
		a_d         = a_q;
		idx_d       = idx_q;
		load_n      = 1'b0;
		cmd         = '0;
		cmd.kind    = KIND_NONE;
		cmd.node    = a_q;
		cmd.n       = n_q;
		cmd.last    = last_node;
		cmd.rd_addr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode) begin
						cmd.clear_sum = 1'b1;
						load_n        = 1'b1;
						a_d           = '0;
						state_d       = S_ROW;
					end else begin
						cmd.wr_req = 1'b1;
					end
				end
			end
			S_ROW: begin
				cmd.rd_en   = 1'b1;
				cmd.kind    = KIND_ROW;
				cmd.rd_addr = a_q;
				idx_d       = '0;
				state_d     = S_COL;
			end
			S_COL: begin
				cmd.rd_en = 1'b1;
				cmd.kind  = KIND_COL;
				if (last_idx) begin
					idx_d   = '0;
					state_d = S_NBR;
				end else begin
					idx_d = idx_q + NODE_W'(1);
				end
			end
			S_NBR: begin
				cmd.rd_en = 1'b1;
				cmd.kind  = KIND_NBR;
				if (last_idx) begin
					state_d = S_DRAIN;
				end else begin
					idx_d = idx_q + NODE_W'(1);
				end
			end
			S_DRAIN: begin
				state_d = S_DIVC;
			end
			S_DIVC: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAITC;
			end
			S_WAITC: begin
				if (sts.div_done) begin
					cmd.take_coef = 1'b1;
					state_d       = last_node ? S_AVG : S_EMIT;
				end
			end
			S_AVG: begin
				cmd.div_start = 1'b1;
				cmd.div_avg   = 1'b1;
				state_d       = S_WAITA;
			end
			S_WAITA: begin
				cmd.div_avg = 1'b1;
				if (sts.div_done) begin
					cmd.take_avg = 1'b1;
					state_d      = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					if (last_node) begin
						state_d = S_IDLE;
					end else begin
						a_d     = a_q + NODE_W'(1);
						state_d = S_ROW;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nc_q    <= CNT_W'(64);
			n_q     <= CNT_W'(1);
			a_q     <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			a_q     <= a_d;
			idx_q   <= idx_d;
			if (load_n) begin
				n_q <= n_eff;
			end
			if (cfg_valid) begin
				nc_q <= cfg_data;
			end
		end
	end

endmodule

/* sv/lcc_checker.sv */
// Port-level checker for the clustering coefficient block, with its bind.
`include "local_clustering_coefficient_assert.svh"

module lcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        mode,
	input logic [5:0]  row_index,
	input logic [63:0] row_bits,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [6:0]  cfg_data,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  node_index,
	input logic [5:0]  degree,
	input logic [11:0] triad_count,
	input logic [15:0] coefficient,
	input logic [15:0] average,
	input logic        last
);

	// a stalled result holds
	`LCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(node_index) && $stable(coefficient) && $stable(last))

	// the mean appears only on the final item
	`LCC_ASSERT_NOW(a_avg_last, out_valid, last || (average == 16'd0))

	// fewer than two neighbours gives no triads and no coefficient
	`LCC_ASSERT_NOW(a_low_degree, out_valid && (degree < 6'd2),
		(triad_count == 12'd0) && (coefficient == 16'd0))

	// a compute item closes the input channel
	`LCC_ASSERT_NEXT(a_walk_busy, in_valid && in_ready && mode, !in_ready)

endmodule

bind local_clustering_coefficient lcc_checker u_lcc_checker (.*);
